/* sv/status_led_pulse_encoder_macros.svh */
// Assertion macros shared by the status LED pulse encoder modules.
// Define ASSERT_OFF to compile every assertion away.
`ifndef STATUS_LED_PULSE_ENCODER_MACROS_SVH
`define STATUS_LED_PULSE_ENCODER_MACROS_SVH
`ifndef ASSERT_OFF
`define SLPE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define SLPE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SLPE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define SLPE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

/* sv/slpe_pkg.sv */
// Types and constants of the status LED pulse encoder.
// No dependencies; imported by every module of the block.
package slpe_pkg;

  localparam int COND_W         = 3;
  localparam int COLOR_W        = 24;
  localparam int BYTE_W         = 8;
  localparam int BRIGHT_W       = 8;
  localparam int PROD_W         = 16;
  localparam int SIG_W          = 32;
  localparam int TICK_W         = 10;
  localparam int CFG_IDX_W      = 3;
  localparam int NUM_COLORS     = 6;
  localparam int BITS_PER_FRAME = 24;
  localparam int SYM_IDX_W      = 5;
  localparam int QDEPTH         = 2;
  localparam int QPTR_W         = $clog2(QDEPTH);
  localparam int QCNT_W         = $clog2(QDEPTH + 1);

  localparam logic [BRIGHT_W-1:0] BRIGHT_RESET = 8'd255;
  localparam logic [SYM_IDX_W-1:0] LAST_SYM_IDX = 5'(BITS_PER_FRAME);

  localparam logic [TICK_W-1:0] ZERO_HIGH_TICKS = 10'd4;
  localparam logic [TICK_W-1:0] ZERO_LOW_TICKS  = 10'd9;
  localparam logic [TICK_W-1:0] ONE_HIGH_TICKS  = 10'd8;
  localparam logic [TICK_W-1:0] ONE_LOW_TICKS   = 10'd5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLOR_STARTING     = 3'd0,
    CFG_COLOR_ONLINE       = 3'd1,
    CFG_COLOR_ON_BATTERY   = 3'd2,
    CFG_COLOR_LOW_BATTERY  = 3'd3,
    CFG_COLOR_FAULT        = 3'd4,
    CFG_COLOR_DISCONNECTED = 3'd5,
    CFG_BRIGHTNESS         = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [BYTE_W-1:0] g;
    logic [BYTE_W-1:0] r;
    logic [BYTE_W-1:0] b;
  } grb_t;

endpackage

/* sv/status_led_pulse_encoder.sv */
// Top level of the status LED pulse encoder: front, frame queue and back.
// Depends on slpe_pkg, slpe_front, slpe_queue and slpe_back.
//
// A condition code is taken while in_stall is low. A code whose
// colour and brightness match the last frame sent produces nothing; any
// other code produces a frame of 25 symbols (24 data bits, G,R,B, MSB
// first, then a low reset symbol with out_last_symbol set). The serializer
// emits one symbol per cycle while out_stall is low. A frame passes the
// palette lookup and multiply, the divide by 255, the queue and the output
// register. The queue holds two scaled frames, the one going out among
// them, so the input accepts codes while a frame goes out until the front
// stages fill. The reset symbol carries RESET_TICKS truncated to 10 bits.
module status_led_pulse_encoder import slpe_pkg::*; #(
  parameter int RESET_TICKS = 1000
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COLOR_W-1:0]   cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [COND_W-1:0]    in_condition,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_first_level,
  output logic [TICK_W-1:0]    out_first_ticks,
  output logic                 out_second_level,
  output logic [TICK_W-1:0]    out_second_ticks,
  output logic                 out_last_symbol
);

  localparam logic [TICK_W-1:0] RstTicks = TICK_W'(RESET_TICKS % (1 << TICK_W));

  logic push_valid, push_ready, pop_valid, pop_ready;
  grb_t push_frame, pop_frame;

  slpe_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_condition (in_condition),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_frame   (push_frame)
  );

  slpe_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_frame (push_frame),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_frame  (pop_frame)
  );

  slpe_back #(
    .RST_TICKS (RstTicks)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .pop_valid        (pop_valid),
    .pop_ready        (pop_ready),
    .pop_frame        (pop_frame),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_first_level  (out_first_level),
    .out_first_ticks  (out_first_ticks),
    .out_second_level (out_second_level),
    .out_second_ticks (out_second_ticks),
    .out_last_symbol  (out_last_symbol)
  );

endmodule

/* sv/slpe_queue.sv */
// Short frame queue between the classifier front and the serializer back.
// Depends on slpe_pkg for the frame type and depth.
module slpe_queue import slpe_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  grb_t push_frame,
  output logic pop_valid,
  input  logic pop_ready,
  output grb_t pop_frame
);

  grb_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push, do_pop;

  assign push_ready = (count_r != QCNT_W'(QDEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_frame  = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_frame;
    end
  end

endmodule

/* sv/slpe_front.sv */
// Front of the encoder: palette and brightness registers, change detection
// and colour scaling. Depends on slpe_pkg and the assertion macro header.
`include "status_led_pulse_encoder_macros.svh"
module slpe_front import slpe_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COLOR_W-1:0]   cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [COND_W-1:0]    in_condition,
  output logic                 push_valid,
  input  logic                 push_ready,
  output grb_t                 push_frame
);

  function automatic logic [BYTE_W-1:0] div255(input logic [PROD_W-1:0] x);
    logic [PROD_W:0] t;
    t = {1'b0, x} + (PROD_W+1)'(x[PROD_W-1:BYTE_W]) + 1'b1;
    return t[PROD_W-1:BYTE_W];
  endfunction

  logic [COLOR_W-1:0]  palette_r [NUM_COLORS];
  logic [BRIGHT_W-1:0] bright_r;
  logic [SIG_W-1:0]    last_sig_r;
  logic                has_sent_r, has_sent_nxt;
  logic                a_valid_r, a_valid_nxt;
  logic                b_valid_r, b_valid_nxt;
  logic [PROD_W-1:0]   prod_g_r, prod_r_r, prod_b_r;
  grb_t                b_frame_r;

  logic [COLOR_W-1:0]  rgb;
  logic [SIG_W-1:0]    sig;
  logic                send, in_accept;
  logic                a_move, a_free, b_free;

  assign rgb = (in_condition < COND_W'(NUM_COLORS)) ? palette_r[in_condition] : '0;
  assign sig = {rgb, bright_r};
  assign send = !has_sent_r || (sig != last_sig_r);

  assign b_free    = !b_valid_r || push_ready;
  assign a_move    = a_valid_r && b_free;
  assign a_free    = !a_valid_r || b_free;
  assign in_stall  = !a_free;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    a_valid_nxt  = (a_valid_r && !b_free) || (in_accept && send);
    b_valid_nxt  = (b_valid_r && !push_ready) || a_move;
    has_sent_nxt = has_sent_r || (in_accept && send);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_COLORS; i++) begin
        palette_r[i] <= '0;
      end
      bright_r   <= BRIGHT_RESET;
      has_sent_r <= 1'b0;
      a_valid_r  <= 1'b0;
      b_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index < CFG_IDX_W'(NUM_COLORS)) begin
          palette_r[cfg_index] <= cfg_data;
        end else if (cfg_index == CFG_BRIGHTNESS) begin
          bright_r <= cfg_data[BRIGHT_W-1:0];
        end
      end
      has_sent_r <= has_sent_nxt;
      a_valid_r  <= a_valid_nxt;
      b_valid_r  <= b_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && send) begin
      last_sig_r <= sig;
      prod_g_r   <= PROD_W'(rgb[15:8])  * PROD_W'(bright_r);
      prod_r_r   <= PROD_W'(rgb[23:16]) * PROD_W'(bright_r);
      prod_b_r   <= PROD_W'(rgb[7:0])   * PROD_W'(bright_r);
    end
    if (a_move) begin
      b_frame_r.g <= div255(prod_g_r);
      b_frame_r.r <= div255(prod_r_r);
      b_frame_r.b <= div255(prod_b_r);
    end
  end

  assign push_valid = b_valid_r;
  assign push_frame = b_frame_r;

  `SLPE_ASSERT_IMPL(a_p_sent_flag, clk, rst_n, a_valid_r || b_valid_r, has_sent_r, "frame in flight before any send")
  `SLPE_ASSERT_NEXT(a_p_hold_a, clk, rst_n, rst_n && a_valid_r && !b_free, a_valid_r, "stage A dropped while blocked")
  `SLPE_ASSERT_NEXT(a_p_sig_upd, clk, rst_n, rst_n && in_accept && send, last_sig_r == $past(sig), "signature not recorded")

endmodule

/* sv/slpe_back.sv */
// Back of the encoder: serializes one queued frame into 24 bit symbols and
// a closing reset symbol. Depends on slpe_pkg and the assertion macro header.
`include "status_led_pulse_encoder_macros.svh"
module slpe_back import slpe_pkg::*; #(
  parameter logic [TICK_W-1:0] RST_TICKS = 10'd1000
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  grb_t              pop_frame,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_first_level,
  output logic [TICK_W-1:0] out_first_ticks,
  output logic              out_second_level,
  output logic [TICK_W-1:0] out_second_ticks,
  output logic              out_last_symbol
);

  logic [SYM_IDX_W-1:0] idx_r, idx_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 first_level_r, second_level_r, last_r;
  logic [TICK_W-1:0]    first_ticks_r, second_ticks_r;
  logic                 load, at_last, cur_bit;
  logic [SYM_IDX_W-1:0] bit_sel;

  assign load    = pop_valid && (!out_valid_r || !out_stall);
  assign at_last = (idx_r == LAST_SYM_IDX);
  assign bit_sel = SYM_IDX_W'(BITS_PER_FRAME - 1) - idx_r;
  assign cur_bit = pop_frame[bit_sel];
  assign pop_ready = load && at_last;

  always_comb begin
    idx_nxt = idx_r;
    if (load) begin
      idx_nxt = at_last ? '0 : idx_r + 1'b1;
    end
    out_valid_nxt = load || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (at_last) begin
        first_level_r  <= 1'b0;
        first_ticks_r  <= RST_TICKS;
        second_level_r <= 1'b0;
        second_ticks_r <= RST_TICKS;
        last_r         <= 1'b1;
      end else begin
        first_level_r  <= 1'b1;
        first_ticks_r  <= cur_bit ? ONE_HIGH_TICKS : ZERO_HIGH_TICKS;
        second_level_r <= 1'b0;
        second_ticks_r <= cur_bit ? ONE_LOW_TICKS : ZERO_LOW_TICKS;
        last_r         <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_first_level  = first_level_r;
  assign out_first_ticks  = first_ticks_r;
  assign out_second_level = second_level_r;
  assign out_second_ticks = second_ticks_r;
  assign out_last_symbol  = last_r;

  `SLPE_ASSERT_IMPL(a_b_idx_range, clk, rst_n, 1'b1, idx_r <= LAST_SYM_IDX, "symbol index out of range")
  `SLPE_ASSERT_IMPL(a_b_frame_held, clk, rst_n, idx_r != '0, pop_valid, "frame lost mid-serialization")
  `SLPE_ASSERT_NEXT(a_b_stall_idx, clk, rst_n, rst_n && out_valid_r && out_stall, $stable(idx_r), "index moved under stall")

endmodule
